### src/aor_pkg.sv
// Package for the box overlap resolver: widths, word layouts and stage payload types.
// Depends on nothing; every module of the block imports it.
package aor_pkg;

   localparam int COORD_BITS     = 24;
   localparam int HALF_BITS      = COORD_BITS - 2;
   localparam int PUSH_FRAC_BITS = 8;
   localparam int PUSH_BITS      = PUSH_FRAC_BITS + 1;
   localparam int DELTA_BITS     = COORD_BITS + 1;
   localparam int SUM_BITS       = HALF_BITS + 1;
   localparam int OV_BITS        = COORD_BITS + 2;
   localparam int MAG_BITS       = HALF_BITS + 1;
   localparam int PROD_BITS      = MAG_BITS + PUSH_BITS;
   localparam int DIR_BITS       = 2;

   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + 4 * HALF_BITS + PUSH_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 4 * COORD_BITS + 2 * DIR_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [HALF_BITS-1:0]  half_type;
   typedef logic        [PUSH_BITS-1:0]  push_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic        [SUM_BITS-1:0]   sum_type;
   typedef logic signed [OV_BITS-1:0]    ov_type;
   typedef logic        [MAG_BITS-1:0]   mag_type;
   typedef logic signed [DIR_BITS-1:0]   dir_type;

   localparam push_type PUSH_ONE = push_type'(1 << PUSH_FRAC_BITS);

   localparam dir_type DIR_POS  = 2'sb01;
   localparam dir_type DIR_NEG  = 2'sb11;
   localparam dir_type DIR_NONE = 2'sb00;

   // last field in the lowest bits
   typedef struct packed {
      push_type  push_share;
      half_type  b_half_h;
      half_type  b_half_w;
      coord_type b_center_y;
      coord_type b_center_x;
      half_type  a_half_h;
      half_type  a_half_w;
      coord_type a_center_y;
      coord_type a_center_x;
   } req_data_type;

   typedef struct packed {
      dir_type   dir_y;
      dir_type   dir_x;
      coord_type b_move_y;
      coord_type b_move_x;
      coord_type a_move_y;
      coord_type a_move_x;
   } rsp_data_type;

   typedef struct packed {
      delta_type dx;
      delta_type dy;
      sum_type   sum_w;
      sum_type   sum_h;
      push_type  push;
   } s1_type;

   typedef struct packed {
      ov_type   ov_x;
      ov_type   ov_y;
      logic     dpos_x;
      logic     dpos_y;
      push_type push;
   } s2_type;

   typedef struct packed {
      logic     hit;
      logic     axis_x;
      logic     dpos;
      mag_type  mag;
      push_type share_a;
      push_type share_b;
   } s3_type;

   typedef struct packed {
      logic    hit;
      logic    axis_x;
      logic    dpos;
      mag_type move_a;
      mag_type move_b;
   } s4_type;

   typedef struct packed {
      logic         hit;
      rsp_data_type data;
   } s5_type;

endpackage

### src/aor_overlap.sv
// Overlap front end: centre deltas and half-size sums, then per-axis overlap.
// Two register stages; depends on aor_pkg.
module aor_overlap (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  aor_pkg::req_data_type in_data,
   output logic                 in_ready,
   output logic                 out_valid_ff,
   input  logic                 out_ready,
   output aor_pkg::s2_type      out_data_ff
);
   import aor_pkg::*;

   logic      v1_ff;
   s1_type    s1_ff;
   s1_type    s1_in;
   s2_type    s2_in;
   logic      ready1;
   logic      ready2;
   delta_type abs_x;
   delta_type abs_y;

   assign ready2   = !out_valid_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      s1_in.dx    = delta_type'({in_data.b_center_x[COORD_BITS-1], in_data.b_center_x})
                  - delta_type'({in_data.a_center_x[COORD_BITS-1], in_data.a_center_x});
      s1_in.dy    = delta_type'({in_data.b_center_y[COORD_BITS-1], in_data.b_center_y})
                  - delta_type'({in_data.a_center_y[COORD_BITS-1], in_data.a_center_y});
      s1_in.sum_w = {1'b0, in_data.a_half_w} + {1'b0, in_data.b_half_w};
      s1_in.sum_h = {1'b0, in_data.a_half_h} + {1'b0, in_data.b_half_h};
      s1_in.push  = (in_data.push_share > PUSH_ONE) ? PUSH_ONE : in_data.push_share;
   end

   always_comb begin
      abs_x        = s1_ff.dx[DELTA_BITS-1] ? -s1_ff.dx : s1_ff.dx;
      abs_y        = s1_ff.dy[DELTA_BITS-1] ? -s1_ff.dy : s1_ff.dy;
      s2_in.ov_x   = ov_type'({1'b0, abs_x})
                   - ov_type'({{(OV_BITS-SUM_BITS){1'b0}}, s1_ff.sum_w});
      s2_in.ov_y   = ov_type'({1'b0, abs_y})
                   - ov_type'({{(OV_BITS-SUM_BITS){1'b0}}, s1_ff.sum_h});
      s2_in.dpos_x = !s1_ff.dx[DELTA_BITS-1] && (s1_ff.dx != '0);
      s2_in.dpos_y = !s1_ff.dy[DELTA_BITS-1] && (s1_ff.dy != '0);
      s2_in.push   = s1_ff.push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) out_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) s1_ff <= s1_in;
      if (ready2 && v1_ff) out_data_ff <= s2_in;
   end

endmodule

### src/aor_select.sv
// Axis choice: hit test, smaller penetration axis (ties to Y), magnitude and shares.
// One register stage; depends on aor_pkg.
module aor_select (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  aor_pkg::s2_type in_data,
   output logic            in_ready,
   output logic            out_valid_ff,
   input  logic            out_ready,
   output aor_pkg::s3_type out_data_ff
);
   import aor_pkg::*;

   s3_type s3_in;
   ov_type sel_ov;
   ov_type neg_ov;

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      s3_in.hit     = in_data.ov_x[OV_BITS-1] && in_data.ov_y[OV_BITS-1];
      s3_in.axis_x  = in_data.ov_x > in_data.ov_y;
      sel_ov        = s3_in.axis_x ? in_data.ov_x : in_data.ov_y;
      neg_ov        = -sel_ov;
      s3_in.mag     = neg_ov[MAG_BITS-1:0];
      s3_in.dpos    = s3_in.axis_x ? in_data.dpos_x : in_data.dpos_y;
      s3_in.share_a = PUSH_ONE - in_data.push;
      s3_in.share_b = in_data.push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) out_data_ff <= s3_in;
   end

endmodule

### src/aor_scale.sv
// Move split: two share products, then sign and axis placement into the output register.
// Two register stages; depends on aor_pkg.
module aor_scale (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  aor_pkg::s3_type in_data,
   output logic            in_ready,
   output logic            out_valid_ff,
   input  logic            out_ready,
   output aor_pkg::s5_type out_data_ff
);
   import aor_pkg::*;

   logic                   v4_ff;
   s4_type                 s4_ff;
   s4_type                 s4_in;
   s5_type                 s5_in;
   logic                   ready4;
   logic                   ready5;
   logic [PROD_BITS-1:0]   prod_a;
   logic [PROD_BITS-1:0]   prod_b;
   logic [COORD_BITS-1:0]  ext_a;
   logic [COORD_BITS-1:0]  ext_b;
   coord_type              move_a;
   coord_type              move_b;
   dir_type                dir;

   assign ready5   = !out_valid_ff || out_ready;
   assign ready4   = !v4_ff || ready5;
   assign in_ready = ready4;

   always_comb begin
      prod_a        = PROD_BITS'(in_data.mag) * PROD_BITS'(in_data.share_a);
      prod_b        = PROD_BITS'(in_data.mag) * PROD_BITS'(in_data.share_b);
      s4_in.hit     = in_data.hit;
      s4_in.axis_x  = in_data.axis_x;
      s4_in.dpos    = in_data.dpos;
      s4_in.move_a  = prod_a[PUSH_FRAC_BITS +: MAG_BITS];
      s4_in.move_b  = prod_b[PUSH_FRAC_BITS +: MAG_BITS];
   end

   always_comb begin
      ext_a  = COORD_BITS'(s4_ff.move_a);
      ext_b  = COORD_BITS'(s4_ff.move_b);
      move_a = s4_ff.dpos ? coord_type'(-ext_a) : coord_type'(ext_a);
      move_b = s4_ff.dpos ? coord_type'(ext_b) : coord_type'(-ext_b);
      dir    = s4_ff.dpos ? DIR_POS : DIR_NEG;
      s5_in  = '0;
      s5_in.hit = s4_ff.hit;
      if (s4_ff.hit) begin
         if (s4_ff.axis_x) begin
            s5_in.data.a_move_x = move_a;
            s5_in.data.b_move_x = move_b;
            s5_in.data.dir_x    = dir;
            s5_in.data.dir_y    = DIR_NONE;
         end else begin
            s5_in.data.a_move_y = move_a;
            s5_in.data.b_move_y = move_b;
            s5_in.data.dir_y    = dir;
            s5_in.data.dir_x    = DIR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready4) v4_ff <= in_valid;
         if (ready5) out_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && in_valid) s4_ff <= s4_in;
      if (ready5 && v4_ff) out_data_ff <= s5_in;
   end

endmodule

### src/aabb_overlap_resolve_core.sv
// Top level of the box overlap resolver: stream ports, word unpacking, five-stage pipeline.
// Depends on aor_pkg, aor_overlap, aor_select and aor_scale.
//
//   channel  | dir | tdata                         | tuser
//   req_     | in  | two boxes and push share      | -
//   rsp_     | out | moves and contact direction   | hit
//
// An accepted req_ word passes through the five register stages to its rsp_ word.
// One word per cycle sustained while rsp_ is not stalled.
// Reset clears only the stage valid bits.
// A stalled rsp_ holds the output register; empty stages behind it keep filling.
module aabb_overlap_resolve_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_center_x, a_center_y, a_half_w, a_half_h, b_center_x, b_center_y,
   // b_half_w, b_half_h, push_share, zero fill
   input  logic [aor_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // a_move_x, a_move_y, b_move_x, b_move_y, dir_x, dir_y, zero fill
   output logic [aor_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // hit
   output logic                                rsp_tuser
);
   import aor_pkg::*;

   req_data_type req_data;
   logic         ov_valid;
   s2_type       ov_data;
   logic         sel_ready;
   logic         sel_valid;
   s3_type       sel_data;
   logic         scl_ready;
   s5_type       scl_data;

   assign req_data = req_data_type'(req_tdata[REQ_FIELD_BITS-1:0]);

   aor_overlap u_overlap (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_data      (req_data),
      .in_ready     (req_tready),
      .out_valid_ff (ov_valid),
      .out_ready    (sel_ready),
      .out_data_ff  (ov_data)
   );

   aor_select u_select (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (ov_valid),
      .in_data      (ov_data),
      .in_ready     (sel_ready),
      .out_valid_ff (sel_valid),
      .out_ready    (scl_ready),
      .out_data_ff  (sel_data)
   );

   aor_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sel_valid),
      .in_data      (sel_data),
      .in_ready     (scl_ready),
      .out_valid_ff (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data_ff  (scl_data)
   );

   assign rsp_tdata = RSP_TDATA_BITS'(scl_data.data);
   assign rsp_tuser = scl_data.hit;

endmodule

### src/aor_checker.sv
// Port-level checks for the box overlap resolver, bound to the top level.
// Depends on aor_pkg and aabb_overlap_resolve_core.
module aor_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [aor_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tuser
);
   import aor_pkg::*;

   rsp_data_type rsp_data;

   assign rsp_data = rsp_data_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss word carries a move or direction");

   a_one_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         ((rsp_data.dir_x == DIR_NONE) != (rsp_data.dir_y == DIR_NONE)) &&
         (rsp_data.dir_x == DIR_NONE || rsp_data.dir_x == DIR_POS ||
          rsp_data.dir_x == DIR_NEG) &&
         (rsp_data.dir_y == DIR_NONE || rsp_data.dir_y == DIR_POS ||
          rsp_data.dir_y == DIR_NEG))
      else $error("hit word without exactly one contact axis");

   a_push_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_data.dir_x == DIR_POS |->
         rsp_data.a_move_x <= 0 && rsp_data.b_move_x >= 0)
      else $error("x moves do not push the boxes apart");

endmodule

bind aabb_overlap_resolve_core aor_checker u_aor_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
